>>> hw/rtl/hbw_pkg.sv
// shared types and constants for the heartbeat watchdog
package hbw_pkg;

	localparam int DEVICES_DEF = 8;
	localparam int DEV_W       = 3;
	localparam int REQ_W       = 2;
	localparam int TIME_W      = 32;
	localparam int NUM_REGS    = 8;
	localparam int REG_IDX_W   = 3;
	localparam int CFG_IDX_W   = 4;

	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;

	localparam logic [REQ_W-1:0] REQ_HEARTBEAT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POLL      = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INIT      = 2'd2;

	// command bits from the sequencer to the timestamp memory
	typedef struct packed {
		logic init;
		logic wr;
		logic rd;
	} ts_ctl_t;

endpackage

>>> hw/rtl/multi_device_heartbeat_watchdog_core.sv
// Heartbeat watchdog for up to eight devices. A heartbeat or init request gives no
// result. A poll request reads the timestamp memory once per device in index order,
// one read per cycle unless the output stalls, and in_ready stays low until the last
// read is issued. Its DEVICES results pass through stage 1 and the output register
// and leave one per cycle for as long as the output is taken. Each result compares
// the wrapping 32-bit elapsed time against the device's timeout register.
// Timeout registers are written through cfg_we, cfg_index and cfg_wdata; indexes of 8
// and above are ignored.
module multi_device_heartbeat_watchdog_core import hbw_pkg::*; #(
	parameter int DEVICES = DEVICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [DEV_W-1:0]     device,
	input  logic [TIME_W-1:0]    now_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DEV_W-1:0]     dev_index,
	output logic                 lost,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_wdata
);

	localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POLL = 1'b1;

	logic              state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] now_q;
	logic              accept;
	logic              issue;
	logic              adv_s1;
	logic              dev_ok;
	ts_ctl_t           ts_ctl;
	logic [IDX_W-1:0]  wr_addr;
	logic [TIME_W-1:0] rd_data;
	logic [TIME_W-1:0] cfg_timeout;

	logic              valid_s1;
	logic [IDX_W-1:0]  dev_s1;
	logic              last_s1;
	logic [TIME_W-1:0] timeout_s1;
	logic [TIME_W-1:0] now_s1;

	logic              out_valid_q;
	logic [DEV_W-1:0]  dev_index_q;
	logic              lost_q;
	logic              last_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign dev_ok   = ({1'b0, device} < (DEV_W + 1)'(DEVICES));
	assign adv_s1   = !out_valid_q || out_ready;
	assign issue    = (state_q == ST_POLL) && (!valid_s1 || adv_s1);

	// writes happen only on accept in idle, reads only in poll: no same-entry overlap
	assign ts_ctl.wr   = accept && (req_type == REQ_HEARTBEAT) && dev_ok;
	assign ts_ctl.init = accept && (req_type == REQ_INIT);
	assign ts_ctl.rd   = issue;
	assign wr_addr     = device[IDX_W-1:0];

	hbw_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.rd_idx     (DEV_W'(idx_q)),
		.rd_timeout (cfg_timeout)
	);

	hbw_ts_mem #(
		.DEVICES (DEVICES),
		.IDX_W   (IDX_W)
	) u_ts_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ts_ctl),
		.wr_addr (wr_addr),
		.wr_data (now_ms),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// poll sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_POLL)) begin
						state_q <= ST_POLL;
						idx_q   <= '0;
					end
				end
				ST_POLL: begin
					if (issue) begin
						if (idx_q == IDX_W'(DEVICES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_POLL)) begin
			now_q <= now_ms;
		end
	end

	// stage 1: memory read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			dev_s1     <= idx_q;
			last_s1    <= (idx_q == IDX_W'(DEVICES - 1));
			timeout_s1 <= cfg_timeout;
			now_s1     <= now_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			dev_index_q <= DEV_W'(dev_s1);
			lost_q      <= (now_s1 - rd_data) > timeout_s1;
			last_q      <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign dev_index = dev_index_q;
	assign lost      = lost_q;
	assign last      = last_q;

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ts_ctl.rd && (ts_ctl.wr || ts_ctl.init)))
		else $error("timestamp read and write in the same cycle");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(dev_s1) && $stable(rd_data)))
		else $error("stalled stage 1 lost its entry");

	a_last_is_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (dev_index_q == DEV_W'(DEVICES - 1)))
		else $error("last flag on wrong device");

	a_poll_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (idx_q == IDX_W'(DEVICES - 1))) |=> (state_q == ST_IDLE))
		else $error("poll did not end after final read");

endmodule

>>> hw/rtl/hbw_cfg.sv
// per-device timeout registers with a write port and one indexed read port
module hbw_cfg import hbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_wdata,
	input  logic [DEV_W-1:0]     rd_idx,
	output logic [TIME_W-1:0]    rd_timeout
);

	logic [TIME_W-1:0] timeout_q [NUM_REGS];
	logic              wr_hit;

	assign wr_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				timeout_q[i] <= TIMEOUT_RST;
			end
		end else if (wr_hit) begin
			timeout_q[cfg_index[REG_IDX_W-1:0]] <= cfg_wdata;
		end
	end

	assign rd_timeout = timeout_q[rd_idx[REG_IDX_W-1:0]];

endmodule

>>> hw/rtl/hbw_ts_mem.sv
// last-heartbeat timestamp memory, registered read, epoch base for init
module hbw_ts_mem import hbw_pkg::*; #(
	parameter int DEVICES = DEVICES_DEF,
	parameter int IDX_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ts_ctl_t           ctl,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [TIME_W-1:0] wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [TIME_W-1:0] rd_data
);

	logic [TIME_W-1:0] mem [DEVICES];
	logic [DEVICES-1:0] valid_q;
	logic [TIME_W-1:0] base_q;
	logic [TIME_W-1:0] rd_raw_q;
	logic [TIME_W-1:0] rd_base_q;
	logic              rd_hit_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued, so a stalled consumer keeps it
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_raw_q  <= mem[rd_addr];
			rd_base_q <= base_q;
		end
	end

	// entries not written since reset or the last init read as the base time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			base_q   <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (ctl.init) begin
				valid_q <= '0;
				base_q  <= wr_data;
			end else if (ctl.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_raw_q : rd_base_q;

endmodule

>>> dv/hbw_status_checker.sv
// request monitor and scoreboard for the heartbeat watchdog poll results
module hbw_status_checker import hbw_pkg::*; #(
	parameter int DEVICES = DEVICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [DEV_W-1:0]     device,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DEV_W-1:0]     dev_index,
	input  logic                 lost,
	input  logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_wdata,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic             lost;
		logic             last;
	} dev_status_t;

	logic [TIME_W-1:0] tmo_ref [NUM_REGS];
	logic [TIME_W-1:0] beat_ms [DEVICES];
	dev_status_t       status_q [$];
	int                errs = 0;

	function automatic void note_mismatch(input string what, input int exp_v, input int act_v);
		errs++;
		if (errs <= 10)
			$display("mismatch: %s expected %0d got %0d", what, exp_v, act_v);
	endfunction

	// updates the timestamp table and queues the statuses a poll should report
	function automatic void apply_request(input logic [REQ_W-1:0] rt,
			input logic [DEV_W-1:0] dv, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] elapsed;
		dev_status_t       st;
		case (rt)
			REQ_HEARTBEAT: begin
				if (dv < DEVICES)
					beat_ms[dv] = t;
			end
			REQ_INIT: begin
				for (int i = 0; i < DEVICES; i++)
					beat_ms[i] = t;
			end
			REQ_POLL: begin
				for (int i = 0; i < DEVICES; i++) begin
					// wraps modulo 2^32 on purpose
					elapsed = t - beat_ms[i];
					st.dev  = DEV_W'(i);
					st.lost = elapsed > tmo_ref[i];
					st.last = (i == DEVICES - 1);
					status_q.push_back(st);
				end
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dev_status_t exp_st;
		if (!arst_n) begin
			foreach (tmo_ref[i])
				tmo_ref[i] = TIMEOUT_RST;
			foreach (beat_ms[i])
				beat_ms[i] = '0;
			status_q.delete();
			pending    <= 0;
			fail_count <= errs;
		end else begin
			if (cfg_we && cfg_index < NUM_REGS)
				tmo_ref[cfg_index[REG_IDX_W-1:0]] = cfg_wdata;
			if (in_valid && in_ready)
				apply_request(req_type, device, now_ms);
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					note_mismatch("result with nothing pending, dev_index", -1,
						int'(dev_index));
				end else begin
					exp_st = status_q.pop_front();
					if (dev_index !== exp_st.dev)
						note_mismatch("dev_index", int'(exp_st.dev), int'(dev_index));
					if (lost !== exp_st.lost)
						note_mismatch($sformatf("lost of device %0d", exp_st.dev),
							int'(exp_st.lost), int'(lost));
					if (last !== exp_st.last)
						note_mismatch($sformatf("last of device %0d", exp_st.dev),
							int'(exp_st.last), int'(last));
				end
			end
			pending    <= status_q.size();
			fail_count <= errs;
		end
	end

endmodule

>>> dv/multi_device_heartbeat_watchdog_core_tb.sv
// stimulus, reset and verdict for the heartbeat watchdog testbench
module multi_device_heartbeat_watchdog_core_tb;
	import hbw_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX  = '1;
	localparam int MAX_GAP       = 8;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASES        = 4;
	localparam int PHASE_ITEMS   = 38;
	localparam int CYCLE_LIMIT   = 200000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [REQ_W-1:0]     req_type  = '0;
	logic [DEV_W-1:0]     device    = '0;
	logic [TIME_W-1:0]    now_ms    = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DEV_W-1:0]     dev_index;
	logic                 lost;
	logic                 last;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int cycles = 0;

	// stimulus side bookkeeping, only used to aim polls at timeout boundaries
	logic [TIME_W-1:0] beat_at [DEVICES_DEF];
	logic [TIME_W-1:0] timeout_at [NUM_REGS];
	logic [TIME_W-1:0] clock_ms;
	bit                quiet    = 1'b0;
	bit                hold_out = 1'b0;

	always #1 clk = ~clk;

	multi_device_heartbeat_watchdog_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.device    (device),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dev_index (dev_index),
		.lost      (lost),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	hbw_status_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.device     (device),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dev_index  (dev_index),
		.lost       (lost),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (mismatches),
		.pending    (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_device_heartbeat_watchdog_core_tb: FAIL");
			$finish;
		end
	end

	task automatic send_req(input logic [REQ_W-1:0] rt, input logic [DEV_W-1:0] dv,
			input logic [TIME_W-1:0] t);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		device   <= dv;
		now_ms   <= t;
		do @(posedge clk); while (!in_ready);
		if (rt == REQ_HEARTBEAT)
			beat_at[dv] = t;
		else if (rt == REQ_INIT)
			foreach (beat_at[i])
				beat_at[i] = t;
	endtask

	// stop offering requests and wait until every poll result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx < NUM_REGS)
			timeout_at[idx[REG_IDX_W-1:0]] = val;
	endtask

	// mode 0: low half zero, high half all ones; mode 1: small; otherwise a mix
	task automatic program_timeouts(input int mode);
		logic [TIME_W-1:0] v;
		for (int i = 0; i < NUM_REGS; i++) begin
			case (mode)
				0: v = (i < NUM_REGS / 2) ? '0 : TIME_MAX;
				1: v = $urandom_range(0, 100);
				default: begin
					case ($urandom_range(0, 3))
						0: v = '0;
						1: v = TIME_MAX;
						2: v = $urandom_range(0, 100);
						default: v = $urandom;
					endcase
				end
			endcase
			write_reg(CFG_IDX_W'(i), v);
		end
		// out of range index must leave every timeout alone
		write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), $urandom);
		cfg_we <= 1'b0;
	endtask

	// response side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int stall;
		forever begin
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : tx_side
		int               n;
		int               r;
		logic [DEV_W-1:0] d;
		logic [TIME_W-1:0] t;
		foreach (beat_at[i])
			beat_at[i] = '0;
		foreach (timeout_at[i])
			timeout_at[i] = TIMEOUT_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timeouts: boundary, wrap and ignored request code
		send_req(REQ_POLL, 3'd0, 32'd0);
		send_req(REQ_POLL, 3'd0, 32'd1000);
		send_req(REQ_POLL, 3'd7, 32'd1001);
		send_req(REQ_HEARTBEAT, 3'd7, 32'd5000);
		send_req(REQ_HEARTBEAT, 3'd0, TIME_MAX);
		send_req(REQ_UNUSED, 3'd7, TIME_MAX);
		send_req(REQ_POLL, 3'd2, 32'd5500);
		send_req(REQ_INIT, 3'd5, 32'hFFFF_FC18);
		send_req(REQ_POLL, 3'd0, 32'd0);
		send_req(REQ_POLL, 3'd4, 32'd1);
		send_req(REQ_HEARTBEAT, 3'd3, 32'd10);
		send_req(REQ_POLL, 3'd1, 32'd5);

		// zero and maximum timeouts
		drain();
		program_timeouts(0);
		send_req(REQ_INIT, 3'd0, 32'd100);
		send_req(REQ_POLL, 3'd0, 32'd100);
		send_req(REQ_POLL, 3'd6, 32'd101);
		send_req(REQ_POLL, 3'd0, 32'd99);
		send_req(REQ_HEARTBEAT, 3'd6, TIME_MAX);
		send_req(REQ_HEARTBEAT, 3'd5, 32'd0);
		send_req(REQ_POLL, 3'd0, 32'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			program_timeouts(ph == 0 ? 1 : 2);
			quiet    = (ph == 1 || ph == 2);
			hold_out = (ph == 2);
			clock_ms = (ph == PHASES - 1) ? TIME_MAX - $urandom_range(0, 400) : $urandom;
			send_req(REQ_INIT, DEV_W'($urandom_range(0, 7)), clock_ms);
			n = 1;
			while (n < PHASE_ITEMS) begin
				clock_ms = clock_ms + $urandom_range(0, 40);
				// back-to-back polls while the receiver is held off
				if (ph == 2 && n < 12) begin
					send_req(REQ_POLL, DEV_W'($urandom_range(0, 7)), clock_ms);
					n++;
					if (n == 12)
						quiet = 1'b0;
					continue;
				end
				if (n == PHASE_ITEMS / 2)
					drain();
				r = $urandom_range(0, 99);
				d = DEV_W'($urandom_range(0, 7));
				if (r < 40) begin
					send_req(REQ_HEARTBEAT, d, clock_ms);
				end else if (r < 70) begin
					send_req(REQ_POLL, DEV_W'($urandom_range(0, 7)), clock_ms);
				end else if (r < 80) begin
					// right at or just past one device's deadline
					t = beat_at[d] + timeout_at[d] + $urandom_range(0, 1);
					send_req(REQ_POLL, DEV_W'($urandom_range(0, 7)), t);
				end else if (r < 86) begin
					send_req(REQ_INIT, d, clock_ms);
				end else if (r < 93) begin
					send_req(REQ_UNUSED, d, $urandom);
					continue;
				end else begin
					send_req(r[0] ? REQ_POLL : REQ_HEARTBEAT, d, $urandom);
				end
				n++;
			end
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("multi_device_heartbeat_watchdog_core_tb: PASS");
		else
			$display("multi_device_heartbeat_watchdog_core_tb: FAIL");
		$finish;
	end

endmodule
